[hw/rtl/dedup_pkg.sv]
// Shared types and constants for the per-channel recent dedup filter.
// No dependencies; ctrl, dpath and top use scoped names; the tb imports it.
package dedup_pkg;

  localparam int unsigned CH_W  = 4;
  localparam int unsigned POS_W = 63;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned LB_W  = 6;

  localparam logic [LB_W-1:0]  LOOK_BACK_RESET = LB_W'(20);
  localparam logic [CNT_W-1:0] COUNT_MAX       = '1;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [POS_W-1:0] position;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic [CH_W-1:0]  out_channel;
    logic [POS_W-1:0] out_position;
    logic [CNT_W-1:0] kept_index;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // request taken, start history row read
    logic commit;  // decide, write back, fill output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_blocked;  // output register full and stalled
  } sts_t;

endpackage

[hw/rtl/dedup_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dedup_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic                                re_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dedup_ctrl.sv]
// Sequencer for the dedup filter: take a request, then commit it.
// Depends on dedup_pkg (cmd_t, sts_t).
module dedup_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dedup_pkg::sts_t   sts_i,
  output dedup_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // hold the row until the output register can take the result
        if (!sts_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/dedup_dpath.sv]
// Datapath: per-channel counts, history row RAM, parallel compare, output register.
// Depends on dedup_pkg and dedup_ram.
module dedup_dpath #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned WINDOW   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dedup_pkg::in_t                    in_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output dedup_pkg::out_t                   out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dedup_pkg::LB_W-1:0]        cfg_wdata_i,
  input  dedup_pkg::cmd_t                   cmd_i,
  output dedup_pkg::sts_t                   sts_o
);

  localparam int unsigned CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned N_W    = $clog2(WINDOW + 1);
  localparam int unsigned ROW_W  = WINDOW * dedup_pkg::POS_W;
  // wide enough for window sizes and ages up to 2*WINDOW
  localparam int unsigned AGE_W  = $clog2(2 * WINDOW + 1) + 1;

  logic [dedup_pkg::LB_W-1:0]  look_back_q;
  logic [dedup_pkg::CNT_W-1:0] cnt_q [CHANNELS];
  logic [SLOT_W-1:0]           wp_q  [CHANNELS];

  logic [dedup_pkg::CH_W-1:0]  ch_q;
  logic [dedup_pkg::POS_W-1:0] pos_q;
  logic                        ch_ok_q;
  logic [dedup_pkg::CNT_W-1:0] cnt_sel_q;
  logic [SLOT_W-1:0]           wp_sel_q;
  logic [N_W-1:0]              n_q;

  logic                        out_valid_q;
  dedup_pkg::out_t             out_q;

  // load-side lookups
  logic                        ch_ok;
  logic [CH_AW-1:0]            ch_idx;
  logic [dedup_pkg::CNT_W-1:0] cnt_sel;
  logic [SLOT_W-1:0]           wp_sel;
  logic [AGE_W-1:0]            lim;
  logic [AGE_W-1:0]            n_full;

  assign ch_ok  = {1'b0, in_data_i.channel} < (dedup_pkg::CH_W + 1)'(CHANNELS);
  assign ch_idx = CH_AW'(in_data_i.channel);

  always_comb begin
    cnt_sel = '0;
    wp_sel  = '0;
    if (ch_ok) begin
      cnt_sel = cnt_q[ch_idx];
      wp_sel  = wp_q[ch_idx];
    end
    lim = AGE_W'(look_back_q);
    if (lim > AGE_W'(WINDOW)) begin
      lim = AGE_W'(WINDOW);
    end
    n_full = lim;
    if (cnt_sel < dedup_pkg::CNT_W'(lim)) begin
      n_full = AGE_W'(cnt_sel);
    end
  end

  // history rows, one per channel
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_wr;
  logic             row_we;

  dedup_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (CH_AW'(ch_q)),
    .wdata_i (row_wr),
    .re_i    (cmd_i.load & ch_ok),
    .raddr_i (ch_idx),
    .rdata_o (row_rd)
  );

  // compare: slot j is in range if its age behind the write pointer is below n
  logic [WINDOW-1:0] hit;
  logic              found;
  logic              accept;

  always_comb begin
    logic [AGE_W-1:0] age;
    age = '0;
    for (int j = 0; j < WINDOW; j++) begin
      age = AGE_W'(wp_sel_q) + AGE_W'(WINDOW - 1 - j);
      if (age >= AGE_W'(WINDOW)) begin
        age = age - AGE_W'(WINDOW);
      end
      hit[j] = (row_rd[j*dedup_pkg::POS_W +: dedup_pkg::POS_W] == pos_q) &&
               (age < AGE_W'(n_q));
    end
  end

  assign found  = |hit;
  assign accept = ch_ok_q & ~found;
  assign row_we = cmd_i.commit & accept;

  always_comb begin
    row_wr = row_rd;
    for (int j = 0; j < WINDOW; j++) begin
      if (SLOT_W'(j) == wp_sel_q) begin
        row_wr[j*dedup_pkg::POS_W +: dedup_pkg::POS_W] = pos_q;
      end
    end
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_back_q <= dedup_pkg::LOOK_BACK_RESET;
    end else if (cfg_we_i) begin
      look_back_q <= cfg_wdata_i;
    end
  end

  // per-channel count and ring pointer (pointer tracks count mod WINDOW)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_q[c] <= '0;
        wp_q[c]  <= '0;
      end
    end else if (row_we && (cnt_sel_q != dedup_pkg::COUNT_MAX)) begin
      cnt_q[CH_AW'(ch_q)] <= cnt_sel_q + dedup_pkg::CNT_W'(1);
      if (wp_sel_q == SLOT_W'(WINDOW - 1)) begin
        wp_q[CH_AW'(ch_q)] <= '0;
      end else begin
        wp_q[CH_AW'(ch_q)] <= wp_sel_q + SLOT_W'(1);
      end
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q      <= in_data_i.channel;
      pos_q     <= in_data_i.position;
      ch_ok_q   <= ch_ok;
      cnt_sel_q <= cnt_sel;
      wp_sel_q  <= wp_sel;
      n_q       <= N_W'(n_full);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.accepted     <= accept;
      out_q.out_channel  <= ch_q;
      out_q.out_position <= pos_q;
      out_q.kept_index   <= cnt_sel_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign sts_o.out_blocked = out_valid_q & out_stall_i;

endmodule

[hw/rtl/per_channel_recent_dedup_filter_core.sv]
// Top level of the per-channel recent dedup filter: controller plus datapath.
// Depends on dedup_pkg, dedup_ctrl, dedup_dpath (which holds dedup_ram).
//
//   port group   dir  handshake              payload
//   in           in   in_valid_i/in_stall_o   dedup_pkg::in_t  (channel, position)
//   out          out  out_valid_o/out_stall_i dedup_pkg::out_t (accepted, echo, index)
//   cfg          in   cfg_we_i                cfg_wdata_i      (look_back)
//
// Per request: the accept cycle issues the channel's history row read, then the look
// state compares the whole row in parallel and writes it back; it waits there while
// the output register is full and stalled, and takes no new request until it commits.
// Reset clears counts, sets look_back to 20; no clearing pass, history needs none.
module per_channel_recent_dedup_filter_core #(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned WINDOW   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dedup_pkg::in_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dedup_pkg::out_t            out_data_o,
  input  logic                       cfg_we_i,
  input  logic [dedup_pkg::LB_W-1:0] cfg_wdata_i
);

  dedup_pkg::cmd_t cmd;
  dedup_pkg::sts_t sts;

  dedup_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dedup_dpath #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[dv/tb.sv]
// Testbench for per_channel_recent_dedup_filter_core: directed table plus random records,
// every result checked against its typed row or a behavioral duplicate-window model here.
// Depends on dedup_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;
  import dedup_pkg::*;

  localparam int unsigned CHANNELS   = 16;
  localparam int unsigned WINDOW     = 32;
  localparam int unsigned IDLE_PCT   = 34;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned PHASES     = 10;
  localparam int unsigned PHASE_REQS = 143;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;
  typedef enum logic {EXP_MODEL, EXP_TYPED} row_exp_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [LB_W-1:0]  lb;
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] pos;
    row_exp_e         exp;
    logic             t_acc;
    logic [CNT_W-1:0] t_kept;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_REQ, 6'd0,  4'd0,  63'd0,   EXP_TYPED, 1'b1, 32'd0},
    '{ROW_REQ, 6'd0,  4'd0,  63'd0,   EXP_TYPED, 1'b0, 32'd1},
    '{ROW_REQ, 6'd0,  4'd0,  POS_MAX, EXP_TYPED, 1'b1, 32'd1},
    '{ROW_REQ, 6'd0,  4'd15, POS_MAX, EXP_TYPED, 1'b1, 32'd0},
    '{ROW_REQ, 6'd0,  4'd15, POS_MAX, EXP_TYPED, 1'b0, 32'd1},
    '{ROW_REQ, 6'd0,  4'd15, 63'd0,   EXP_TYPED, 1'b1, 32'd1},
    '{ROW_REQ, 6'd0,  4'd7,  63'h5555_5555_5555_5555, EXP_TYPED, 1'b1, 32'd0},
    '{ROW_REQ, 6'd0,  4'd7,  63'h2AAA_AAAA_AAAA_AAAA, EXP_TYPED, 1'b1, 32'd1},
    // look-back zero: duplicates go through
    '{ROW_CFG, 6'd0,  4'd0,  63'd0,   EXP_MODEL, 1'b0, 32'd0},
    '{ROW_REQ, 6'd0,  4'd0,  63'd0,   EXP_TYPED, 1'b1, 32'd2},
    '{ROW_REQ, 6'd0,  4'd0,  63'd0,   EXP_TYPED, 1'b1, 32'd3},
    '{ROW_CFG, 6'd1,  4'd0,  63'd0,   EXP_MODEL, 1'b0, 32'd0},
    '{ROW_REQ, 6'd0,  4'd0,  63'd0,   EXP_TYPED, 1'b0, 32'd4},
    '{ROW_REQ, 6'd0,  4'd0,  POS_MAX, EXP_MODEL, 1'b0, 32'd0},
    '{ROW_REQ, 6'd0,  4'd0,  63'd0,   EXP_MODEL, 1'b0, 32'd0},
    // look-back past and at the ring depth
    '{ROW_CFG, 6'd63, 4'd0,  63'd0,   EXP_MODEL, 1'b0, 32'd0},
    '{ROW_REQ, 6'd0,  4'd0,  POS_MAX, EXP_MODEL, 1'b0, 32'd0},
    '{ROW_CFG, 6'd32, 4'd0,  63'd0,   EXP_MODEL, 1'b0, 32'd0},
    '{ROW_REQ, 6'd0,  4'd15, 63'd0,   EXP_MODEL, 1'b0, 32'd0},
    '{ROW_CFG, LOOK_BACK_RESET, 4'd0, 63'd0, EXP_MODEL, 1'b0, 32'd0}
  };

  logic            clk_i;
  logic            rst_ni    = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_t             in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [LB_W-1:0] cfg_wdata = '0;

  per_channel_recent_dedup_filter_core #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // filter model state
  logic [POS_W-1:0] hist_pos [CHANNELS][WINDOW];
  logic [CNT_W-1:0] acc_cnt  [CHANNELS];
  logic [LB_W-1:0]  look_back_q;

  out_t pending_results [$];
  int   fails = 0;

  // positions sent per channel, used to aim duplicates
  logic [POS_W-1:0] sent_pos [CHANNELS][64];
  int unsigned      sent_n   [CHANNELS];

  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int unsigned hold_left = 0;

  function automatic out_t filter_record(in_t rec);
    out_t             r;
    logic [CNT_W-1:0] cnt;
    int unsigned      n;
    logic             hit;
    int unsigned      slot;
    r.out_channel  = rec.channel;
    r.out_position = rec.position;
    r.accepted     = 1'b0;
    r.kept_index   = '0;
    if (rec.channel < CHANNELS) begin
      cnt = acc_cnt[rec.channel];
      n   = (look_back_q > WINDOW) ? WINDOW : look_back_q;
      if (n > cnt) n = cnt;
      hit = 1'b0;
      for (int unsigned k = 0; k < n; k++) begin
        slot = (cnt - 32'd1 - k) % WINDOW;
        if (hist_pos[rec.channel][slot] == rec.position) hit = 1'b1;
      end
      r.kept_index = cnt;
      r.accepted   = !hit;
      if (!hit) begin
        slot = cnt % WINDOW;
        hist_pos[rec.channel][slot] = rec.position;
        if (cnt != COUNT_MAX) acc_cnt[rec.channel] = cnt + 32'd1;
      end
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(logic [CH_W-1:0] ch);
    int unsigned roll;
    int unsigned depth;
    int unsigned k;
    roll = $urandom_range(0, 99);
    if (sent_n[ch] > 0 && roll < 50) begin
      depth = (sent_n[ch] > 48) ? 48 : sent_n[ch];
      k = $urandom_range(0, depth - 1);
      return sent_pos[ch][(sent_n[ch] - 1 - k) % 64];
    end else if (roll < 60) begin
      return POS_W'($urandom_range(0, 7));
    end
    return POS_W'({$urandom, $urandom});
  endfunction

  task automatic note_sent(in_t req);
    sent_pos[req.channel][sent_n[req.channel] % 64] = req.position;
    sent_n[req.channel]++;
  endtask

  // valid stays high after an accept; the next call either reloads or drops it
  task automatic send_req(in_t req);
    if (!quiet_tx) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_results.push_back(filter_record(req));
    note_sent(req);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_look_back(logic [LB_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    look_back_q = v;
    cfg_we <= 1'b0;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request pending: %h", got);
      fails++;
    end else begin
      want = pending_results.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        fails++;
      end
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
        fails++;
      end
      if (got.out_position !== want.out_position) begin
        $error("out_position: expected %h, got %h", want.out_position, got.out_position);
        fails++;
      end
      if (got.kept_index !== want.kept_index) begin
        $error("kept_index: expected %0d, got %0d", want.kept_index, got.kept_index);
        fails++;
      end
    end
  endtask

  // result side: check, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) check_result(out_data);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet_rx) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  int unsigned stuck_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_ni) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stim
    in_t             req;
    out_t            typed_exp;
    logic [LB_W-1:0] lb;
    for (int c = 0; c < CHANNELS; c++) begin
      acc_cnt[c] = '0;
      sent_n[c]  = 0;
    end
    look_back_q = LOOK_BACK_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_look_back(DIR_ROWS[i].lb);
      end else begin
        req.channel  = DIR_ROWS[i].ch;
        req.position = DIR_ROWS[i].pos;
        send_req(req);
        if (DIR_ROWS[i].exp == EXP_TYPED) begin
          typed_exp = pending_results.pop_back();
          typed_exp.accepted   = DIR_ROWS[i].t_acc;
          typed_exp.kept_index = DIR_ROWS[i].t_kept;
          pending_results.push_back(typed_exp);
        end
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: lb = LOOK_BACK_RESET;
        1: lb = 6'd32;
        2: lb = 6'd33;
        3: lb = 6'd63;
        4: lb = 6'd0;
        5: lb = 6'd1;
        6: lb = 6'd2;
        7: lb = 6'd7;
        8: lb = 6'd31;
        default: lb = LB_W'($urandom_range(0, 63));
      endcase
      write_look_back(lb);
      quiet_tx = (ph == 3);
      quiet_rx = (ph == 3);
      if (ph == 5) hold_reqs++;
      for (int n = 0; n < PHASE_REQS; n++) begin
        // back-to-back pressure while the result side holds off
        if (ph == 5) quiet_tx = (n < 60);
        if (ph == 6 && n == 70) wait_drained();
        if ($urandom_range(0, 99) < 50) req.channel = CH_W'($urandom_range(0, 2));
        else req.channel = CH_W'($urandom_range(0, 15));
        req.position = pick_pos(req.channel);
        send_req(req);
      end
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
